/* src/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/uhcr_pkg.sv */
// shared types and constants of the uart hex command responder
`timescale 1ns / 1ps
package uhcr_pkg;

  // request kinds as carried in the slave tuser
  localparam logic [1:0] KIND_RX    = 2'd0;
  localparam logic [1:0] KIND_CHECK = 2'd1;
  localparam logic [1:0] KIND_POLL  = 2'd2;
  localparam logic [1:0] KIND_NOP   = 2'd3;

  // command status codes
  localparam logic [2:0] STATUS_NONE    = 3'd0;
  localparam logic [2:0] STATUS_SHORT   = 3'd1;
  localparam logic [2:0] STATUS_BAD_END = 3'd2;
  localparam logic [2:0] STATUS_BAD_HEX = 3'd3;
  localparam logic [2:0] STATUS_OFF     = 3'd4;
  localparam logic [2:0] STATUS_ON      = 3'd5;
  localparam logic [2:0] STATUS_REPLY   = 3'd6;
  localparam logic [2:0] STATUS_UNKNOWN = 3'd7;

  // ascii
  localparam logic [7:0] ASCII_LF   = 8'h0a;
  localparam logic [7:0] ASCII_CR   = 8'h0d;
  localparam logic [7:0] ASCII_DOT  = 8'h2e;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // request queue depth, power of two
  localparam int QUEUE_DEPTH = 2;

  // classified request as held in the queue
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic       tx_ready;
    logic [7:0] digit_hi;
    logic [7:0] digit_lo;
  } req_t;

endpackage

/* src/uhcr_front.sv */
// front end: unpacks and classifies incoming requests
`timescale 1ns / 1ps
module uhcr_front
  import uhcr_pkg::*;
(
  input  logic        s_tvalid,
  input  logic [23:0] s_tdata,
  input  logic [1:0]  s_tuser,
  output logic        push_valid,
  output req_t        push_data
);

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    begin
      if (v < 4'd10) c = ASCII_ZERO + {4'h0, v};
      else           c = 8'h57 + {4'h0, v};
      return c;
    end
  endfunction

  assign push_valid = s_tvalid;

  always_comb begin
    push_data.kind     = s_tuser;
    push_data.rx_byte  = s_tdata[7:0];
    push_data.tx_ready = s_tdata[8];
    // adc sample pre-converted to lowercase hex
    push_data.digit_hi = hex_char(s_tdata[16:13]);
    push_data.digit_lo = hex_char(s_tdata[12:9]);
  end

endmodule

/* src/uhcr_fifo.sv */
// short request queue between front and back
`timescale 1ns / 1ps
module uhcr_fifo
  import uhcr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  req_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output req_t pop_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  req_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != CW'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PW'(1);
      if (do_push && !do_pop)      fill <= fill + CW'(1);
      else if (!do_push && do_pop) fill <= fill - CW'(1);
    end
  end

endmodule

/* src/uhcr_back.sv */
// back end: frame buffer, command decode, reply sequencer, result register
`timescale 1ns / 1ps
module uhcr_back
  import uhcr_pkg::*;
#(
  parameter int RX_LIMIT = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  req_t       pop_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_tx_valid,
  output logic [7:0] out_byte,
  output logic       out_led,
  output logic [2:0] out_status
);

  localparam int CW = $clog2(RX_LIMIT + 1);

  localparam int FRAME_MIN = 15;
  localparam int POS_HI    = 10;
  localparam int POS_LO    = 11;
  localparam int POS_DOT   = 12;
  localparam int POS_CR    = 13;
  localparam int POS_LF    = 14;
  localparam int CMD_LEN   = 4;
  localparam int UUID_LEN  = 33;
  localparam int VALUE_LEN = 6;

  localparam logic [8*CMD_LEN-1:0]  CMD_TEXT  = "suw,";
  localparam logic [8*UUID_LEN-1:0] UUID_TEXT = "35648ed618b34375b9fdd7f7a059c34c,";

  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_VALUE = 2'd1;
  localparam logic [1:0] PHASE_UUID  = 2'd2;
  localparam logic [1:0] PHASE_CMD   = 2'd3;

  localparam logic [1:0] MSG_CMD   = 2'd0;
  localparam logic [1:0] MSG_UUID  = 2'd1;
  localparam logic [1:0] MSG_VALUE = 2'd2;

  localparam logic [7:0] CMD_LED_OFF = 8'h00;
  localparam logic [7:0] CMD_LED_ON  = 8'h01;
  localparam logic [7:0] CMD_REPLY   = 8'h02;

  // nibble value, bit 4 set for a non-hex character
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    begin
      v = 5'h10;
      if (c[7:4] == 4'h3) begin
        if (c[3:0] < 4'd10) v = {1'b0, c[3:0]};
      end else if (c[7:4] == 4'h4 || c[7:4] == 4'h6) begin
        if (c[3:0] > 4'd0 && c[3:0] < 4'd7) v = {1'b0, c[3:0]} + 5'd9;
      end
      return v;
    end
  endfunction

  logic [7:0]    rx_buf [RX_LIMIT+1];
  logic [CW-1:0] rx_count, rx_count_next;
  logic [7:0]    digit_hi, digit_hi_next;
  logic [7:0]    digit_lo, digit_lo_next;
  logic [1:0]    send_phase, send_phase_next;
  logic [1:0]    send_message, send_message_next;
  logic [5:0]    send_index, send_index_next;
  logic [5:0]    send_left, send_left_next;
  logic          led_level, led_level_next;

  logic          exec;
  logic          rx_write;
  logic [4:0]    nib_hi, nib_lo;
  logic [7:0]    cmd;
  logic          tx_valid_next;
  logic [7:0]    byte_next;
  logic [2:0]    status_next;
  logic [7:0]    msg_byte;

  assign pop_ready = !out_valid || out_ready;
  assign exec      = pop_valid && pop_ready;
  assign rx_write  = exec && (pop_data.kind == KIND_RX);
  assign nib_hi    = hex_value(rx_buf[POS_HI]);
  assign nib_lo    = hex_value(rx_buf[POS_LO]);
  assign cmd       = {nib_hi[3:0], nib_lo[3:0]};

  // byte of the message in progress
  always_comb begin
    msg_byte = 8'h00;
    unique case (send_message)
      MSG_CMD: begin
        if (send_index < 6'(CMD_LEN))
          msg_byte = CMD_TEXT[(CMD_LEN - 1 - int'(send_index)) * 8 +: 8];
      end
      MSG_UUID: begin
        if (send_index < 6'(UUID_LEN))
          msg_byte = UUID_TEXT[(UUID_LEN - 1 - int'(send_index)) * 8 +: 8];
      end
      MSG_VALUE: begin
        unique case (send_index)
          6'd0, 6'd1: msg_byte = ASCII_ZERO;
          6'd2:       msg_byte = digit_hi;
          6'd3:       msg_byte = digit_lo;
          6'd4:       msg_byte = ASCII_CR;
          6'd5:       msg_byte = ASCII_LF;
          default:    msg_byte = 8'h00;
        endcase
      end
      default: msg_byte = 8'h00;
    endcase
  end

  always_comb begin
    rx_count_next     = rx_count;
    digit_hi_next     = digit_hi;
    digit_lo_next     = digit_lo;
    send_phase_next   = send_phase;
    send_message_next = send_message;
    send_index_next   = send_index;
    send_left_next    = send_left;
    led_level_next    = led_level;
    tx_valid_next     = 1'b0;
    byte_next         = 8'h00;
    status_next       = STATUS_NONE;
    unique case (pop_data.kind)
      KIND_RX: begin
        if (rx_count < CW'(RX_LIMIT)) rx_count_next = rx_count + CW'(1);
      end
      KIND_CHECK: begin
        if (rx_count < CW'(FRAME_MIN)) begin
          status_next = STATUS_SHORT;
        end else begin
          rx_count_next = '0;
          priority if (rx_buf[POS_LF] != ASCII_LF || rx_buf[POS_CR] != ASCII_CR ||
                       rx_buf[POS_DOT] != ASCII_DOT) begin
            status_next = STATUS_BAD_END;
          end else if (nib_hi[4] || nib_lo[4]) begin
            status_next = STATUS_BAD_HEX;
          end else if (cmd == CMD_LED_OFF) begin
            led_level_next = 1'b0;
            status_next    = STATUS_OFF;
          end else if (cmd == CMD_LED_ON) begin
            led_level_next = 1'b1;
            status_next    = STATUS_ON;
          end else if (cmd == CMD_REPLY) begin
            digit_hi_next   = pop_data.digit_hi;
            digit_lo_next   = pop_data.digit_lo;
            send_phase_next = PHASE_CMD;
            status_next     = STATUS_REPLY;
          end else begin
            status_next = STATUS_UNKNOWN;
          end
        end
      end
      KIND_POLL: begin
        if (send_left == 6'd0) begin
          unique case (send_phase)
            PHASE_CMD: begin
              send_message_next = MSG_CMD;
              send_left_next    = 6'(CMD_LEN);
              send_index_next   = '0;
              send_phase_next   = PHASE_UUID;
            end
            PHASE_UUID: begin
              send_message_next = MSG_UUID;
              send_left_next    = 6'(UUID_LEN);
              send_index_next   = '0;
              send_phase_next   = PHASE_VALUE;
            end
            PHASE_VALUE: begin
              send_message_next = MSG_VALUE;
              send_left_next    = 6'(VALUE_LEN);
              send_index_next   = '0;
              send_phase_next   = PHASE_IDLE;
            end
            default: ;
          endcase
        end else if (pop_data.tx_ready) begin
          tx_valid_next   = 1'b1;
          byte_next       = msg_byte;
          send_index_next = send_index + 6'd1;
          send_left_next  = send_left - 6'd1;
        end
      end
      default: ;
    endcase
  end

  // frame buffer, written at the receive count
  always_ff @(posedge clk) begin
    if (rx_write) rx_buf[rx_count] <= pop_data.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count     <= '0;
      digit_hi     <= ASCII_ZERO;
      digit_lo     <= ASCII_ZERO;
      send_phase   <= PHASE_IDLE;
      send_message <= MSG_CMD;
      send_index   <= '0;
      send_left    <= '0;
      led_level    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (exec) begin
        rx_count     <= rx_count_next;
        digit_hi     <= digit_hi_next;
        digit_lo     <= digit_lo_next;
        send_phase   <= send_phase_next;
        send_message <= send_message_next;
        send_index   <= send_index_next;
        send_left    <= send_left_next;
        led_level    <= led_level_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (exec) begin
      out_tx_valid <= tx_valid_next;
      out_byte     <= byte_next;
      out_led      <= led_level_next;
      out_status   <= status_next;
    end
  end

endmodule

/* src/uart_hex_command_responder_unit.sv */
// top level of the uart hex command responder
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  request kind, rx byte, tx ready, adc sample
// m_*       out  m_tvalid/m_tready  tx flag, tx byte, led level, command status
//
// one request per clock sustained while m_tready stays high; every request yields exactly one result
// a request is first written into the queue; the back end then executes it
// and registers the result in the result register
// s_tready drops only when the two-entry queue is full, i.e. when m_tready
// has been low long enough to back the result register up
// synchronous active-high reset clears counters, sequencer, led and queue
module uart_hex_command_responder_unit
  import uhcr_pkg::*;
#(
  parameter int RX_LIMIT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // rx_byte[7:0], tx_ready[8], adc_sample[16:9], zero pad
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // tx_byte[7:0], led_on[8], cmd_status[11:9], zero pad
  output logic [0:0]  m_tuser    // tx_valid[0]
);

`include "assert_macros.svh"

  // front to queue
  logic       push_valid;
  req_t       push_data;
  // queue to back
  logic       q_valid;
  logic       q_ready;
  req_t       q_data;
  // result register
  logic       res_tx_valid;
  logic [7:0] res_byte;
  logic       res_led;
  logic [2:0] res_status;
  // presented result with and without a byte
  logic       sent_byte;
  logic       no_byte;

  // unpack, classify and hex-convert the adc sample
  uhcr_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // decouples input acceptance from output stalls
  uhcr_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (s_tready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // frame check, led control and reply sequencer
  uhcr_back #(
    .RX_LIMIT (RX_LIMIT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (q_valid),
    .pop_ready    (q_ready),
    .pop_data     (q_data),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_tx_valid (res_tx_valid),
    .out_byte     (res_byte),
    .out_led      (res_led),
    .out_status   (res_status)
  );

  assign m_tdata = {4'h0, res_status, res_led, res_byte};
  assign m_tuser = res_tx_valid;

  assign sent_byte = m_tvalid && res_tx_valid;
  assign no_byte   = m_tvalid && !res_tx_valid;

  // an accepted request is held in the queue or the result register next cycle
  `ASSERT_NEXT(a_req_held, s_tvalid && s_tready, q_valid || m_tvalid, "request lost")

  // a transmitted byte comes only from a poll, which reports no status
  `ASSERT_ALWAYS(a_tx_no_status, !sent_byte || (res_status == STATUS_NONE), "tx with status")

  // no byte is sent, so the byte field is zero
  `ASSERT_ALWAYS(a_idle_byte_zero, !no_byte || (res_byte == 8'h00), "idle byte nonzero")

endmodule
